// ----- hw/rtl/aabb_all_pairs_overlap_table_core_macros.svh -----
// assertion macros for the box overlap table
`ifndef AABB_ALL_PAIRS_OVERLAP_TABLE_CORE_MACROS_SVH
`define AABB_ALL_PAIRS_OVERLAP_TABLE_CORE_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define AOT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define AOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/aot_pkg.sv -----
// ----------------------------------------------------------------------------
// aot_pkg
// types and constants shared by the box overlap table
// ----------------------------------------------------------------------------
package aot_pkg;

  localparam int MaxBoxesDefault = 64;
  localparam int CoordW = 16;
  localparam int ExtW = 15;
  localparam int EntW = 16;
  localparam int SlotW = 6;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_REASSIGN = 3'd2,
    ACT_SCAN = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_SLOT = 2'd1,
    KIND_MOVED = 2'd2,
    KIND_HIT = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [ExtW-1:0] w;
    logic [ExtW-1:0] h;
  } box_t;

  typedef struct packed {
    logic [2:0] action;
    logic [SlotW-1:0] slot;
    logic [EntW-1:0] owner_entity;
    logic signed [CoordW-1:0] corner_x;
    logic signed [CoordW-1:0] corner_y;
    logic [ExtW-1:0] extent_w;
    logic [ExtW-1:0] extent_h;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic error_flag;
    logic [SlotW-1:0] result_slot;
    logic [EntW-1:0] result_entity;
    logic last_of_run;
  } rsp_t;

  // inclusive overlap test with one extra bit so edge sums never wrap
  function automatic logic boxes_touch(box_t a, box_t b);
    logic signed [CoordW:0] ax, ay, bx, by, axe, aye, bxe, bye;
    ax = {a.x[CoordW-1], a.x};
    ay = {a.y[CoordW-1], a.y};
    bx = {b.x[CoordW-1], b.x};
    by = {b.y[CoordW-1], b.y};
    axe = ax + $signed({2'b00, a.w});
    aye = ay + $signed({2'b00, a.h});
    bxe = bx + $signed({2'b00, b.w});
    bye = by + $signed({2'b00, b.h});
    return !(ax > bxe) && !(axe < bx) && !(ay > bye) && !(aye < by);
  endfunction

endpackage

// ----- hw/rtl/aot_if.sv -----
// ----------------------------------------------------------------------------
// aot_req_if / aot_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface aot_req_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [5:0] slot;
  logic [15:0] owner_entity;
  logic signed [15:0] corner_x;
  logic signed [15:0] corner_y;
  logic [14:0] extent_w;
  logic [14:0] extent_h;
  modport source (output valid, action, slot, owner_entity, corner_x, corner_y,
                  extent_w, extent_h, input ready);
  modport sink (input valid, action, slot, owner_entity, corner_x, corner_y,
                extent_w, extent_h, output ready);
endinterface

interface aot_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] result_kind;
  logic error_flag;
  logic [5:0] result_slot;
  logic [15:0] result_entity;
  logic last_of_run;
  modport source (output valid, result_kind, error_flag, result_slot, result_entity,
                  last_of_run, input ready);
  modport sink (input valid, result_kind, error_flag, result_slot, result_entity,
                last_of_run, output ready);
endinterface

// ----- hw/rtl/aot_cell.sv -----
// ----------------------------------------------------------------------------
// aot_cell
// one table slot: holds a box, compares it with the broadcast box,
// and is loaded from the request or from the tail slot on unregister
// ----------------------------------------------------------------------------
module aot_cell (
  input  logic clk,
  input  logic load,
  input  aot_pkg::box_t load_box,
  input  aot_pkg::box_t probe_box,
  input  logic probe_en,
  input  logic clear_hit,
  input  logic set_hit,
  output aot_pkg::box_t box,
  output logic hit
);
  import aot_pkg::*;

  logic touch;

  assign touch = boxes_touch(box, probe_box);

  always_ff @(posedge clk) begin
    if (load) begin
      box <= load_box;
    end
    if (clear_hit) begin
      hit <= 1'b0;
    end else if (set_hit || (probe_en && touch)) begin
      hit <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/aabb_all_pairs_overlap_table_core.sv -----
// ----------------------------------------------------------------------------
// aabb_all_pairs_overlap_table_core
// box table with all-pairs overlap scan over a row of compare cells
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | action, slot, owner_entity, corner, extent
//  rsp     | out | result_kind, error_flag, result_slot, result_entity, last_of_run
//
// one request at a time; after register, unregister, reassign or clear the next
// request is accepted only once the result has been taken
// scan: every slot's box is broadcast in turn, then each slot gets an owner read
// step and an output step, and a closing step ends the walk
// rst clears the count, hit marks and control; box contents stay undefined
// a stalled result holds the walk in place, nothing is dropped
module aabb_all_pairs_overlap_table_core #(
  parameter int MAX_BOXES = aot_pkg::MaxBoxesDefault
) (
  input logic clk,
  input logic rst,
  aot_req_if.sink req,
  aot_rsp_if.source rsp
);
  import aot_pkg::*;

  localparam int CntW = $clog2(MAX_BOXES + 1);
  localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WALK,
    ST_OUT
  } state_t;

  state_t state;
  logic [CntW-1:0] count;
  logic [CntW-1:0] ptr;
  logic any_hit;
  box_t probe_box;
  logic probe_en;
  logic clear_hit;
  logic [MAX_BOXES-1:0] hits;
  box_t cell_box [MAX_BOXES];
  logic [MAX_BOXES-1:0] load_en;
  box_t load_box [MAX_BOXES];
  logic [EntW-1:0] owner_mem [MAX_BOXES];
  logic [EntW-1:0] owner_rd;
  logic [EntW-1:0] owner_last;
  req_t r;
  rsp_t res;
  logic res_valid;
  logic [IdxW-1:0] slot_idx;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] ptr_idx;
  logic [MAX_BOXES-1:0] probe_mark;
  logic [MAX_BOXES-1:0] touch_vec;
  logic [MAX_BOXES-1:0] marked;
  logic [MAX_BOXES-1:0] above_mask;
  logic more_after;

  assign r = '{action: req.action, slot: req.slot, owner_entity: req.owner_entity,
               corner_x: req.corner_x, corner_y: req.corner_y,
               extent_w: req.extent_w, extent_h: req.extent_h};
  assign req.ready = (state == ST_IDLE) && !res_valid;
  assign slot_idx = r.slot[IdxW-1:0];
  assign last_idx = IdxW'(count - CntW'(1));
  assign ptr_idx = ptr[IdxW-1:0];

  assign rsp.valid = res_valid;
  assign rsp.result_kind = res.result_kind;
  assign rsp.error_flag = res.error_flag;
  assign rsp.result_slot = res.result_slot;
  assign rsp.result_entity = res.result_entity;
  assign rsp.last_of_run = res.last_of_run;

  // each cell compares against the broadcast box; only occupied cells other than the probing one record
  genvar g;
  generate
    for (g = 0; g < MAX_BOXES; g++) begin : g_cell
      logic occ;
      logic pself;
      assign occ = (CntW'(g) < count);
      assign pself = (ptr == CntW'(g));
      aot_cell u_cell (
        .clk(clk),
        .load(load_en[g]),
        .load_box(load_box[g]),
        .probe_box(probe_box),
        .probe_en(probe_en && occ && !pself),
        .clear_hit(clear_hit),
        .set_hit(1'b0),
        .box(cell_box[g]),
        .hit(hits[g])
      );
    end
  endgenerate

  // box writes into cells: register into the tail, unregister copies the tail
  always_comb begin
    for (int k = 0; k < MAX_BOXES; k++) begin
      load_en[k] = 1'b0;
      load_box[k] = '{x: r.corner_x, y: r.corner_y, w: r.extent_w, h: r.extent_h};
    end
    if (req.valid && req.ready) begin
      if (r.action == ACT_REGISTER && count < CntW'(MAX_BOXES)) begin
        load_en[count[IdxW-1:0]] = 1'b1;
      end else if (r.action == ACT_UNREGISTER && {1'b0, r.slot} < 7'(count) &&
                   7'(r.slot) < 7'(count - CntW'(1))) begin
        load_en[slot_idx] = 1'b1;
        load_box[slot_idx] = cell_box[last_idx];
      end
    end
  end

  // owner store: registered reads at the walk pointer and at the tail slot;
  // a request is accepted only after the result of the one before has been taken,
  // so owner_last always holds the current tail owner when it is used
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      if (r.action == ACT_REGISTER && count < CntW'(MAX_BOXES)) begin
        owner_mem[count[IdxW-1:0]] <= r.owner_entity;
      end else if (r.action == ACT_UNREGISTER && 7'(r.slot) < 7'(count) &&
                   7'(r.slot) < 7'(count) - 7'd1) begin
        owner_mem[slot_idx] <= owner_last;
      end else if (r.action == ACT_REASSIGN && 7'(r.slot) < 7'(count)) begin
        owner_mem[slot_idx] <= r.owner_entity;
      end
    end
    owner_rd <= owner_mem[ptr_idx];
    owner_last <= owner_mem[last_idx];
  end

  always_comb begin
    probe_box = cell_box[ptr_idx];
    probe_en = (state == ST_PROBE) && (ptr < count);
  end

  // cells mark themselves when hit by another probe; the probing cell is
  // marked separately when any other occupied cell touched it
  always_comb begin
    for (int k = 0; k < MAX_BOXES; k++) begin
      touch_vec[k] = (CntW'(k) < count) && (ptr != CntW'(k)) &&
                     boxes_touch(cell_box[k], probe_box);
      above_mask[k] = (CntW'(k) > ptr) && (CntW'(k) < count);
    end
    marked = hits | probe_mark;
    more_after = |(marked & above_mask);
  end

  always_ff @(posedge clk) begin
    if (rst || clear_hit) begin
      probe_mark <= '0;
    end else if (probe_en && |touch_vec) begin
      probe_mark[ptr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ptr <= '0;
      res_valid <= 1'b0;
      any_hit <= 1'b0;
      clear_hit <= 1'b1;
      res <= '0;
    end else begin
      clear_hit <= 1'b0;
      if (res_valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            res_valid <= 1'b1;
            res <= '{result_kind: KIND_ACK, error_flag: 1'b0, result_slot: '0,
                     result_entity: '0, last_of_run: 1'b1};
            case (r.action)
              ACT_REGISTER: begin
                res.result_kind <= KIND_SLOT;
                if (count >= CntW'(MAX_BOXES)) begin
                  res.error_flag <= 1'b1;
                end else begin
                  res.result_slot <= 6'(count);
                  count <= count + CntW'(1);
                end
              end
              ACT_UNREGISTER: begin
                if (7'(r.slot) >= 7'(count)) begin
                  res.result_kind <= KIND_MOVED;
                  res.error_flag <= 1'b1;
                end else begin
                  count <= count - CntW'(1);
                  if (7'(r.slot) < 7'(count) - 7'd1) begin
                    res.result_kind <= KIND_MOVED;
                    res.result_slot <= r.slot;
                    res.result_entity <= owner_last;
                  end
                end
              end
              ACT_REASSIGN: begin
                if (7'(r.slot) >= 7'(count)) begin
                  res.error_flag <= 1'b1;
                end
              end
              ACT_SCAN: begin
                res_valid <= 1'b0;
                ptr <= '0;
                any_hit <= 1'b0;
                state <= ST_PROBE;
              end
              ACT_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PROBE: begin
          // a probe hit against another cell also marks the probing cell
          if (ptr >= count) begin
            ptr <= '0;
            state <= ST_WALK;
          end else begin
            ptr <= ptr + CntW'(1);
          end
        end
        ST_WALK: begin
          // owner read is registered; each slot passes here first, and waits while a result stalls
          if (!res_valid || rsp.ready) begin
            if (ptr >= count) begin
              if (!any_hit) begin
                res_valid <= 1'b1;
                res <= '{result_kind: KIND_ACK, error_flag: 1'b0, result_slot: '0,
                         result_entity: '0, last_of_run: 1'b1};
              end
              clear_hit <= 1'b1;
              state <= ST_IDLE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (hits[ptr_idx] || probe_mark[ptr_idx]) begin
            res_valid <= 1'b1;
            any_hit <= 1'b1;
            res <= '{result_kind: KIND_HIT, error_flag: 1'b0, result_slot: '0,
                     result_entity: owner_rd, last_of_run: !more_after};
          end
          ptr <= ptr + CntW'(1);
          state <= ST_WALK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/aot_checker.sv -----
// ----------------------------------------------------------------------------
// aot_checker
// port-level checks on the box overlap table
// ----------------------------------------------------------------------------
`include "aabb_all_pairs_overlap_table_core_macros.svh"

module aot_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] rsp_kind,
  input logic rsp_error,
  input logic rsp_last
);
  import aot_pkg::*;

  `AOT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
  `AOT_ASSERT_IMP(a_no_take_busy, clk, rst, rsp_valid, !req_ready, "request taken while busy")
  `AOT_ASSERT_IMP(a_hit_no_err, clk, rst, rsp_valid && rsp_kind == KIND_HIT, !rsp_error, "hit flagged error")
  `AOT_ASSERT_IMP(a_single_last, clk, rst, rsp_valid && rsp_kind != KIND_HIT, rsp_last, "single result not last")

endmodule

bind aabb_all_pairs_overlap_table_core aot_checker u_aot_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.result_kind),
  .rsp_error(rsp.error_flag), .rsp_last(rsp.last_of_run)
);

// ----- bench/tb_aot_if_note.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aot_stim_pkg
// request and result records used by the box table bench
// ----------------------------------------------------------------------------
package tb_aot_stim_pkg;
  import aot_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] slot;
    logic [15:0] owner;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } box_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic err;
    logic [5:0] slot;
    logic [15:0] entity;
    logic last;
  } box_rsp_t;
endpackage

// ----- bench/tb_aabb_all_pairs_overlap_table_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_all_pairs_overlap_table_core
// drives register, unregister, reassign, scan, clear and undefined action requests into the box
// table and checks every result against a predictor kept in step with them
// ----------------------------------------------------------------------------
module tb_aabb_all_pairs_overlap_table_core;
  import aot_pkg::*;
  import tb_aot_stim_pkg::*;

  localparam int NBOX = 64;
  localparam box_rsp_t NoResult = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aot_req_if req ();
  aot_rsp_if rsp ();

  aabb_all_pairs_overlap_table_core #(.MAX_BOXES(NBOX)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the table
  logic [15:0] tbl_owner [NBOX];
  logic signed [16:0] tbl_x [NBOX];
  logic signed [16:0] tbl_y [NBOX];
  logic signed [16:0] tbl_w [NBOX];
  logic signed [16:0] tbl_h [NBOX];
  int tbl_count = 0;

  box_rsp_t pending_results[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit long_stall = 1'b0;

  box_req_t directed_rows[$];
  box_rsp_t typed_results[$];
  bit typed_valid[$];

  function automatic box_rsp_t mk(logic [1:0] k, logic e, logic [5:0] s,
                                  logic [15:0] en, logic l);
    box_rsp_t r;
    r.kind = k;
    r.err = e;
    r.slot = s;
    r.entity = en;
    r.last = l;
    return r;
  endfunction

  function automatic void add_expected(box_rsp_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(box_req_t q, bit typed, box_rsp_t t);
    directed_rows.insert(directed_rows.size(), q);
    typed_valid.insert(typed_valid.size(), typed);
    typed_results.insert(typed_results.size(), t);
  endfunction

  // inclusive bounds, 17-bit edge sums
  function automatic bit touching(int a, int b);
    return !(tbl_x[a] > tbl_x[b] + tbl_w[b]) && !(tbl_x[a] + tbl_w[a] < tbl_x[b]) &&
           !(tbl_y[a] > tbl_y[b] + tbl_h[b]) && !(tbl_y[a] + tbl_h[a] < tbl_y[b]);
  endfunction

  // update the table copy and queue the results one request causes
  task automatic predict_table(box_req_t q);
    logic [63:0] marks;
    int n;
    int lst;
    marks = '0;
    n = 0;
    case (q.action)
      ACT_REGISTER: begin
        if (tbl_count >= NBOX) begin
          add_expected(mk(KIND_SLOT, 1'b1, 6'd0, 16'd0, 1'b1));
        end else begin
          tbl_owner[tbl_count] = q.owner;
          tbl_x[tbl_count] = q.x;
          tbl_y[tbl_count] = q.y;
          tbl_w[tbl_count] = {2'b00, q.w};
          tbl_h[tbl_count] = {2'b00, q.h};
          add_expected(mk(KIND_SLOT, 1'b0, 6'(tbl_count), 16'd0, 1'b1));
          tbl_count++;
        end
      end
      ACT_UNREGISTER: begin
        if (int'(q.slot) >= tbl_count) begin
          add_expected(mk(KIND_MOVED, 1'b1, 6'd0, 16'd0, 1'b1));
        end else begin
          lst = tbl_count - 1;
          tbl_count = lst;
          if (int'(q.slot) < lst) begin
            tbl_owner[q.slot] = tbl_owner[lst];
            tbl_x[q.slot] = tbl_x[lst];
            tbl_y[q.slot] = tbl_y[lst];
            tbl_w[q.slot] = tbl_w[lst];
            tbl_h[q.slot] = tbl_h[lst];
            add_expected(mk(KIND_MOVED, 1'b0, q.slot, tbl_owner[lst], 1'b1));
          end else begin
            add_expected(mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
          end
        end
      end
      ACT_REASSIGN: begin
        if (int'(q.slot) >= tbl_count) begin
          add_expected(mk(KIND_ACK, 1'b1, 6'd0, 16'd0, 1'b1));
        end else begin
          tbl_owner[q.slot] = q.owner;
          add_expected(mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
        end
      end
      ACT_SCAN: begin
        for (int i = 0; i < tbl_count; i++)
          for (int j = i + 1; j < tbl_count; j++)
            if (touching(i, j)) begin
              marks[i] = 1'b1;
              marks[j] = 1'b1;
            end
        for (int i = 0; i < tbl_count; i++)
          if (marks[i]) begin
            add_expected(mk(KIND_HIT, 1'b0, 6'd0, tbl_owner[i], 1'b0));
            n++;
          end
        if (n == 0) add_expected(mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
        else pending_results[$].last = 1'b1;
      end
      ACT_CLEAR: begin
        tbl_count = 0;
        add_expected(mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
      end
      default: begin
        add_expected(mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  int burst_left = 0;

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.slot = '0;
    req.owner_entity = '0;
    req.corner_x = '0;
    req.corner_y = '0;
    req.extent_w = '0;
    req.extent_h = '0;
  end

  // hand over one request: set up at the falling edge, accept on a rising edge
  task automatic send_request(box_req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid <= 1'b1;
    req.action <= q.action;
    req.slot <= q.slot;
    req.owner_entity <= q.owner;
    req.corner_x <= q.x;
    req.corner_y <= q.y;
    req.extent_w <= q.w;
    req.extent_h <= q.h;
    do @(posedge clk); while (!req.ready);
    predict_table(q);
    @(negedge clk);
  endtask

  function automatic box_req_t rq(logic [2:0] a, logic [5:0] s, logic [15:0] o,
                                  logic [15:0] x, logic [15:0] y,
                                  logic [14:0] w, logic [14:0] h);
    box_req_t q;
    q.action = a;
    q.slot = s;
    q.owner = o;
    q.x = x;
    q.y = y;
    q.w = w;
    q.h = h;
    return q;
  endfunction

  // mostly small boxes in a narrow area, with an occasional fully random box, so that overlaps are common
  function automatic box_req_t random_request(int cnt);
    box_req_t q;
    int pick;
    pick = $urandom_range(0, 99);
    q = rq(ACT_REGISTER, 6'($urandom), 16'($urandom),
           16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 2000) - 1000),
           15'($urandom_range(0, 300)), 15'($urandom_range(0, 300)));
    if ($urandom_range(0, 9) == 0) begin
      q.x = 16'($urandom);
      q.y = 16'($urandom);
      q.w = 15'($urandom);
      q.h = 15'($urandom);
    end
    if (cnt > 0 && $urandom_range(0, 3) != 0) q.slot = 6'($urandom_range(0, cnt - 1));
    if (pick < 45) q.action = ACT_REGISTER;
    else if (pick < 60) q.action = ACT_UNREGISTER;
    else if (pick < 72) q.action = ACT_REASSIGN;
    else if (pick < 92) q.action = ACT_SCAN;
    else if (pick < 96) q.action = ACT_CLEAR;
    else q.action = 3'($urandom_range(5, 7));
    return q;
  endfunction

  initial begin
    box_req_t q;
    // rows with an expected result typed in where it is plain
    add_row(rq(ACT_SCAN, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_UNREGISTER, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_MOVED, 1'b1, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_REASSIGN, 6'd0, 16'h1234, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b1, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_REGISTER, 6'd63, 16'hFFFF, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF),
            1'b1, mk(KIND_SLOT, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_REGISTER, 6'd0, 16'h0000, 16'h7FFF, 16'h7FFF, 15'd0, 15'd0), 1'b1,
            mk(KIND_SLOT, 1'b0, 6'd1, 16'd0, 1'b1));
    add_row(rq(ACT_SCAN, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b0, NoResult);
    // touching edges: a at 0..16, b starting at 16
    add_row(rq(ACT_REGISTER, 6'd0, 16'hAAAA, 16'd0, 16'd0, 15'd16, 15'd16), 1'b0,
            NoResult);
    add_row(rq(ACT_REGISTER, 6'd0, 16'h5555, 16'd16, 16'd16, 15'd16, 15'd16), 1'b0,
            NoResult);
    add_row(rq(ACT_SCAN, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b0, NoResult);
    add_row(rq(ACT_REASSIGN, 6'd2, 16'hBEEF, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_UNREGISTER, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_MOVED, 1'b0, 6'd0, 16'h5555, 1'b1));
    add_row(rq(ACT_UNREGISTER, 6'd2, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_UNREGISTER, 6'd63, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_MOVED, 1'b1, 6'd0, 16'd0, 1'b1));
    add_row(rq(3'd5, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(3'd7, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));
    add_row(rq(ACT_SCAN, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b0, NoResult);
    add_row(rq(ACT_CLEAR, 6'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0), 1'b1,
            mk(KIND_ACK, 1'b0, 6'd0, 16'd0, 1'b1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k]);
      // a typed row must agree with the prediction just queued
      if (typed_valid[k] && pending_results[$] != typed_results[k]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: typed kind=%0d err=%0d slot=%0d ent=%h last=%0d / %s",
                   k, typed_results[k].kind, typed_results[k].err,
                   typed_results[k].slot, typed_results[k].entity,
                   typed_results[k].last, "differs from prediction");
      end
    end

    // fill the table to the brim, then overflow it, scan it full, then run random requests with a clear midway
    for (int k = 0; k < NBOX + 2; k++) begin
      q = random_request(tbl_count);
      q.action = ACT_REGISTER;
      if (k == 10) long_stall = 1'b1;
      send_request(q);
    end
    q.action = ACT_SCAN;
    send_request(q);

    for (int k = 0; k < 135; k++) begin
      q = random_request(tbl_count);
      if (k == 70) begin
        q.action = ACT_CLEAR;
      end
      send_request(q);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // receiver: own stall pattern plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int run;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_stall) begin
        long_stall = 1'b0;
        rsp.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 20);
      repeat (run) begin
        case (mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 3) != 0);
          2: rsp.ready <= ($urandom_range(0, 1) == 0);
          default: rsp.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    box_rsp_t got;
    box_rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      got = mk(rsp.result_kind, rsp.error_flag, rsp.result_slot, rsp.result_entity,
               rsp.last_of_run);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d err=%0d slot=%0d ent=%h last=%0d",
                   got.kind, got.err, got.slot, got.entity, got.last);
      end else begin
        exp_r = pending_results.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp kind=%0d err=%0d slot=%0d ent=%h last=%0d %s",
                     exp_r.kind, exp_r.err, exp_r.slot, exp_r.entity, exp_r.last,
                     $sformatf("/ got %0d %0d %0d %h %0d", got.kind, got.err,
                               got.slot, got.entity, got.last));
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- aabb_all_pairs_overlap_table_core.f -----
+incdir+hw/rtl
hw/rtl/aot_pkg.sv
hw/rtl/aot_if.sv
hw/rtl/aot_cell.sv
hw/rtl/aabb_all_pairs_overlap_table_core.sv
hw/rtl/aot_checker.sv
bench/tb_aot_if_note.sv
bench/tb_aabb_all_pairs_overlap_table_core.sv
